// ----- design/lirs_pkg.sv -----
// ----------------------------------------------------------------------------
// lirs_pkg
// Shared types and constants for the linear interpolation resampler with
// channel mapping.
// ----------------------------------------------------------------------------
package lirs_pkg;

   localparam int MAX_CHANNELS = 2;
   localparam int MAX_RUN      = 16;

   localparam int SAMPLE_W = 32;
   localparam int STEP_W   = 21;
   localparam int PHASE_W  = 22;
   localparam int FRAC_W   = 16;
   localparam int CSR_W    = 21;
   localparam int CSR_IDX_W = 2;

   localparam logic [PHASE_W-1:0] UNIT_PHASE = 22'h010000;
   localparam logic [PHASE_W-1:0] PHASE_MAX  = 22'h0FFFFF;
   localparam logic [STEP_W-1:0]  UNIT_STEP  = 21'h010000;

   localparam logic [STEP_W-1:0] RESET_RATE_STEP  = 21'h010000;
   localparam logic [1:0]        RESET_IN_COUNT   = 2'd2;
   localparam logic [1:0]        RESET_OUT_COUNT  = 2'd2;
   localparam logic              RESET_FORMAT     = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_STEP     = 2'd0,
      CSR_IN_CHANNELS   = 2'd1,
      CSR_OUT_CHANNELS  = 2'd2,
      CSR_SAMPLE_FORMAT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STEP_W-1:0] rate_step;
      logic              unit_step;
      logic              in_two;
      logic              out_two;
      logic              wide;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic calc;
      logic finish_empty;
      logic load_out;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic unit_step;
      logic phase_full;
      logic run_end;
      logic out_free;
   } status_type;

endpackage

// ----- design/lirs_csr.sv -----
// ----------------------------------------------------------------------------
// lirs_csr
// Configuration registers with decoded channel and step flags.
// ----------------------------------------------------------------------------
module lirs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [lirs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lirs_pkg::CSR_W-1:0]       csr_write_data,
   output lirs_pkg::cfg_type                cfg
);

   localparam int ChanLimit = (lirs_pkg::MAX_CHANNELS < 2) ? lirs_pkg::MAX_CHANNELS : 2;

   logic [lirs_pkg::STEP_W-1:0] rate_step_ff, rate_step_in;
   logic [1:0]                  in_count_ff, in_count_in;
   logic [1:0]                  out_count_ff, out_count_in;
   logic                        format_ff, format_in;

   always_comb begin
      rate_step_in = rate_step_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      format_in    = format_ff;
      if (csr_write_enable) begin
         case (lirs_pkg::csr_index_type'(csr_index))
            lirs_pkg::CSR_RATE_STEP:     rate_step_in = csr_write_data[lirs_pkg::STEP_W-1:0];
            lirs_pkg::CSR_IN_CHANNELS:   in_count_in  = csr_write_data[1:0];
            lirs_pkg::CSR_OUT_CHANNELS:  out_count_in = csr_write_data[1:0];
            lirs_pkg::CSR_SAMPLE_FORMAT: format_in    = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_step_ff <= lirs_pkg::RESET_RATE_STEP;
         in_count_ff  <= lirs_pkg::RESET_IN_COUNT;
         out_count_ff <= lirs_pkg::RESET_OUT_COUNT;
         format_ff    <= lirs_pkg::RESET_FORMAT;
      end else begin
         rate_step_ff <= rate_step_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         format_ff    <= format_in;
      end
   end

   // zero counts as one, counts above the limit are clamped
   always_comb begin
      cfg.rate_step = rate_step_ff;
      cfg.unit_step = (rate_step_ff == lirs_pkg::UNIT_STEP);
      cfg.in_two    = (in_count_ff >= 2'd2) && (ChanLimit >= 2);
      cfg.out_two   = (out_count_ff >= 2'd2) && (ChanLimit >= 2);
      cfg.wide      = format_ff;
   end

endmodule

// ----- design/lirs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lirs_ctrl
// Controller: sequences capture, product calculation and result loading,
// and counts the results of one run.
// ----------------------------------------------------------------------------
module lirs_ctrl #(
   parameter int MAX_RUN = lirs_pkg::MAX_RUN
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lirs_pkg::status_type status,
   output lirs_pkg::cmd_type    cmd
);

   localparam int RunW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [RunW-1:0] run_cnt_ff, run_cnt_in;
   logic            run_cap;

   assign run_cap = (run_cnt_ff == RunW'(MAX_RUN - 1));

   always_comb begin
      state_in   = state_ff;
      run_cnt_in = run_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               run_cnt_in  = '0;
               state_in    = ST_CALC;
            end
         end
         ST_CALC: begin
            if (status.unit_step) begin
               state_in = ST_EMIT;
            end else if (status.phase_full) begin
               cmd.finish_empty = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.calc = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.last     = status.unit_step || run_cap || status.run_end;
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end else begin
                  run_cnt_in = run_cnt_ff + 1'b1;
                  state_in   = ST_CALC;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         run_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         run_cnt_ff <= run_cnt_in;
      end
   end

   // a run never goes past the cap
   a_run_capped: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && run_cap) |-> cmd.last)
      else $error("run exceeded its cap");

endmodule

// ----- design/lirs_dp.sv -----
// ----------------------------------------------------------------------------
// lirs_dp
// Datapath: sample scaling, previous frame and phase, per-channel
// difference multiply, interpolation add, channel mapping, output register.
// ----------------------------------------------------------------------------
module lirs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lirs_pkg::cfg_type                   cfg,
   input  lirs_pkg::cmd_type                   cmd,
   output lirs_pkg::status_type                status,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_in_sample_a,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_in_sample_b,
   input  logic                                req_discontinuity,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_out_sample_a,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_out_sample_b,
   output logic                                rsp_last_of_run
);

   localparam int SW = lirs_pkg::SAMPLE_W;
   localparam int PW = lirs_pkg::PHASE_W;
   localparam int DW = SW + 1;
   localparam int MW = DW + lirs_pkg::FRAC_W + 1;

   logic signed [SW-1:0] cur_a_ff, cur_a_in, cur_b_ff, cur_b_in;
   logic signed [SW-1:0] prev_a_ff, prev_a_in, prev_b_ff, prev_b_in;
   logic [PW-1:0]        phase_ff, phase_in;
   logic signed [DW-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic                 out_valid_ff, out_valid_in;
   logic signed [SW-1:0] out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic                 out_last_ff, out_last_in;

   logic signed [SW-1:0]                 scaled_a, scaled_b;
   logic signed [DW-1:0]                 diff_a, diff_b, sum_a, sum_b;
   logic signed [lirs_pkg::FRAC_W:0]     frac;
   logic signed [MW-1:0]                 mul_a, mul_b;
   logic signed [SW-1:0]                 val_a, val_b;
   logic [PW-1:0]                        step_next;
   logic                                 out_free;

   function automatic logic [SW-1:0] to_q31(input logic [SW-1:0] raw, input logic wide);
      return wide ? raw : {raw[15:0], 16'h0000};
   endfunction

   // drop one frame of phase, a capped run restarts at zero
   function automatic logic [PW-1:0] phase_wrap(input logic [PW-1:0] p);
      logic [PW-1:0] pm;
      logic [PW-1:0] d;
      pm = (p < lirs_pkg::UNIT_PHASE) ? lirs_pkg::UNIT_PHASE : p;
      d  = pm - lirs_pkg::UNIT_PHASE;
      return (d > lirs_pkg::PHASE_MAX) ? lirs_pkg::PHASE_MAX : d;
   endfunction

   always_comb begin
      scaled_a = to_q31(req_in_sample_a, cfg.wide);
      scaled_b = cfg.in_two ? to_q31(req_in_sample_b, cfg.wide) : '0;

      diff_a = {cur_a_ff[SW-1], cur_a_ff} - {prev_a_ff[SW-1], prev_a_ff};
      diff_b = {cur_b_ff[SW-1], cur_b_ff} - {prev_b_ff[SW-1], prev_b_ff};
      frac   = {1'b0, phase_ff[lirs_pkg::FRAC_W-1:0]};
      mul_a  = diff_a * frac;
      mul_b  = diff_b * frac;

      // floor of the product over 2^16
      prod_a_in = cmd.calc ? mul_a[DW+lirs_pkg::FRAC_W-1:lirs_pkg::FRAC_W] : prod_a_ff;
      prod_b_in = cmd.calc ? mul_b[DW+lirs_pkg::FRAC_W-1:lirs_pkg::FRAC_W] : prod_b_ff;

      sum_a = {prev_a_ff[SW-1], prev_a_ff} + prod_a_ff;
      sum_b = {prev_b_ff[SW-1], prev_b_ff} + prod_b_ff;
      val_a = cfg.unit_step ? cur_a_ff : sum_a[SW-1:0];
      val_b = cfg.unit_step ? cur_b_ff : sum_b[SW-1:0];

      step_next = phase_ff + {1'b0, cfg.rate_step};
      out_free  = !out_valid_ff || rsp_ready;

      cur_a_in  = cmd.capture ? scaled_a : cur_a_ff;
      cur_b_in  = cmd.capture ? scaled_b : cur_b_ff;
      prev_a_in = prev_a_ff;
      prev_b_in = prev_b_ff;
      phase_in  = phase_ff;

      if (cmd.capture && req_discontinuity) begin
         prev_a_in = '0;
         prev_b_in = '0;
         phase_in  = '0;
      end
      if (cmd.finish_empty) begin
         phase_in  = phase_wrap(phase_ff);
         prev_a_in = cur_a_ff;
         prev_b_in = cur_b_ff;
      end
      if (cmd.load_out) begin
         if (cmd.last) begin
            if (!cfg.unit_step) begin
               phase_in = phase_wrap(step_next);
            end
            prev_a_in = cur_a_ff;
            prev_b_in = cur_b_ff;
         end else begin
            phase_in = step_next;
         end
      end

      out_valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
      out_a_in     = cmd.load_out ? val_a : out_a_ff;
      out_b_in     = out_b_ff;
      if (cmd.load_out) begin
         out_b_in = cfg.out_two ? (cfg.in_two ? val_b : val_a) : '0;
      end
      out_last_in  = cmd.load_out ? cmd.last : out_last_ff;

      status.unit_step  = cfg.unit_step;
      status.phase_full = (phase_ff >= lirs_pkg::UNIT_PHASE);
      status.run_end    = (step_next >= lirs_pkg::UNIT_PHASE);
      status.out_free   = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff    <= '0;
         prev_b_ff    <= '0;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         prev_a_ff    <= prev_a_in;
         prev_b_ff    <= prev_b_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_a_ff    <= cur_a_in;
      cur_b_ff    <= cur_b_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_sample_a = out_a_ff;
   assign rsp_out_sample_b = out_b_ff;
   assign rsp_last_of_run  = out_last_ff;

   // a held result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("output register overwritten while held");

   // mid-run phase always lies before the current frame
   a_phase_in_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (cfg.unit_step || (phase_ff < lirs_pkg::UNIT_PHASE)))
      else $error("result loaded with phase past the current frame");

   // stored phase fits its saturated range after a run ends
   a_phase_stored: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish_empty || (cmd.load_out && cmd.last)) |=>
         (phase_ff <= lirs_pkg::PHASE_MAX))
      else $error("stored phase out of range");

endmodule

// ----- design/linear_interp_resampler_upmix_unit.sv -----
// ----------------------------------------------------------------------------
// linear_interp_resampler_upmix_unit
// Linear interpolation sample-rate converter with mono/stereo channel mapping.
// ----------------------------------------------------------------------------
// Each input item is one PCM frame, scaled to Q1.31; the unit emits every
// output frame that falls between the previous and the current frame,
// prev + floor(frac * (cur - prev)), advancing a Q6.16 phase by rate_step,
// with at most MAX_RUN results per item. An accepted item is captured; each
// result then goes through the per-channel product register and then through
// the interpolation add into the output register, which holds it while the
// result side stalls. An item with no results only updates the phase and
// the previous frame. A unit step passes the frame through as one result.
// The next item is taken while the last result of a run still waits in the
// output register. Configuration is to be written only while the unit is
// idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module linear_interp_resampler_upmix_unit #(
   parameter int MAX_RUN = lirs_pkg::MAX_RUN
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lirs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lirs_pkg::CSR_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_in_sample_a,
   input  logic signed [lirs_pkg::SAMPLE_W-1:0] req_in_sample_b,
   input  logic                                 req_discontinuity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_out_sample_a,
   output logic signed [lirs_pkg::SAMPLE_W-1:0] rsp_out_sample_b,
   output logic                                 rsp_last_of_run
);

   lirs_pkg::cfg_type    cfg;
   lirs_pkg::cmd_type    cmd;
   lirs_pkg::status_type status;

   lirs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lirs_ctrl #(
      .MAX_RUN (MAX_RUN)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lirs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_in_sample_a   (req_in_sample_a),
      .req_in_sample_b   (req_in_sample_b),
      .req_discontinuity (req_discontinuity),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_sample_a  (rsp_out_sample_a),
      .rsp_out_sample_b  (rsp_out_sample_b),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ----- tb/tb_linear_interp_resampler_upmix_unit.sv -----
// ----------------------------------------------------------------------------
// tb_linear_interp_resampler_upmix_unit
// Self-checking bench for the linear interpolation resampler with channel
// mapping. PCM frames go in on the req channel and interpolated frames come
// back on the rsp channel. Both sides idle and stall at random. A predictor
// inside the bench tracks the held frame, the phase and the register set,
// and queues the frames each accepted item should cause. A checker compares
// every accepted result with the oldest queued frame. Directed tests cover
// the unit step, the run cap, phase saturation, channel mapping from mono to
// stereo and back, and discontinuities. Randomised streams then run under changing settings.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler_upmix_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ONE_FRAME = lirs_pkg::UNIT_PHASE;
   localparam int          SW        = lirs_pkg::SAMPLE_W;

   typedef logic [lirs_pkg::CSR_W-1:0] csr_word_type;

   typedef struct packed {
      logic signed [SW-1:0] sample_a;
      logic signed [SW-1:0] sample_b;
      logic                 last;
   } out_frame_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_write_enable = 1'b0;
   logic [lirs_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [lirs_pkg::CSR_W-1:0]         csr_write_data = '0;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic signed [SW-1:0]               req_in_sample_a = '0;
   logic signed [SW-1:0]               req_in_sample_b = '0;
   logic                               req_discontinuity = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [SW-1:0]               rsp_out_sample_a;
   logic signed [SW-1:0]               rsp_out_sample_b;
   logic                               rsp_last_of_run;

   // predictor state and register copy
   logic [lirs_pkg::STEP_W-1:0] cfg_rate_step = lirs_pkg::RESET_RATE_STEP;
   logic [1:0]                  cfg_in_count  = lirs_pkg::RESET_IN_COUNT;
   logic [1:0]                  cfg_out_count = lirs_pkg::RESET_OUT_COUNT;
   logic                        cfg_wide      = lirs_pkg::RESET_FORMAT;
   logic signed [SW-1:0]        held_frame [2] = '{default: '0};
   logic [19:0]                 phase_acc = '0;

   out_frame_type pending_frames[$];
   bit            no_idle = 1'b0;
   int            mismatch_count = 0;
   int            items_sent = 0;
   int            results_checked = 0;
   int            settings_applied = 0;

   always #6 clock = ~clock;

   linear_interp_resampler_upmix_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_sample_a  (req_in_sample_a),
      .req_in_sample_b  (req_in_sample_b),
      .req_discontinuity(req_discontinuity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_sample_a (rsp_out_sample_a),
      .rsp_out_sample_b (rsp_out_sample_b),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   function automatic int draw_wait();
      if (no_idle) begin
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   function automatic logic [1:0] clamp_count(logic [1:0] c);
      int lim;
      lim = (lirs_pkg::MAX_CHANNELS < 2) ? lirs_pkg::MAX_CHANNELS : 2;
      if (c == 2'd0) begin
         return 2'd1;
      end
      if (int'(c) > lim) begin
         return 2'(lim);
      end
      return c;
   endfunction

   function automatic logic signed [SW-1:0] scale_to_q31(logic [SW-1:0] raw);
      if (cfg_wide) begin
         return $signed(raw);
      end
      return $signed({raw[15:0], 16'h0000});
   endfunction

   // prev + floor(frac * (cur - prev))
   function automatic logic signed [SW-1:0] interp_point(
      logic signed [SW-1:0] from_s, logic signed [SW-1:0] to_s,
      logic [lirs_pkg::FRAC_W-1:0] frac);
      logic signed [63:0] wide_from;
      logic signed [63:0] wide_to;
      logic signed [63:0] prod;
      logic signed [63:0] sum;
      wide_from = from_s;
      wide_to   = to_s;
      prod      = (wide_to - wide_from) * $signed({48'd0, frac});
      sum       = wide_from + (prod >>> lirs_pkg::FRAC_W);
      return sum[SW-1:0];
   endfunction

   function automatic out_frame_type map_channels(logic signed [SW-1:0] v0,
      logic signed [SW-1:0] v1, logic [1:0] ich, logic [1:0] och);
      out_frame_type f;
      f.sample_a = v0;
      f.sample_b = '0;
      if (och >= 2'd2) begin
         f.sample_b = (ich >= 2'd2) ? v1 : v0;
      end
      f.last = 1'b0;
      return f;
   endfunction

   task automatic predict_frames(input logic [SW-1:0] raw_a,
      input logic [SW-1:0] raw_b, input logic disc);
      logic [1:0]           ich;
      logic [1:0]           och;
      logic signed [SW-1:0] cur0;
      logic signed [SW-1:0] cur1;
      int unsigned          pos;
      out_frame_type        run_q[$];
      ich = clamp_count(cfg_in_count);
      och = clamp_count(cfg_out_count);
      if (disc) begin
         held_frame[0] = '0;
         held_frame[1] = '0;
         phase_acc     = '0;
      end
      cur0 = scale_to_q31(raw_a);
      cur1 = (ich >= 2'd2) ? scale_to_q31(raw_b) : '0;
      if (cfg_rate_step == lirs_pkg::UNIT_STEP) begin
         run_q.push_back(map_channels(cur0, cur1, ich, och));
      end else begin
         pos = phase_acc;
         while (pos < ONE_FRAME && run_q.size() < lirs_pkg::MAX_RUN) begin
            run_q.push_back(map_channels(interp_point(held_frame[0], cur0, pos[15:0]),
                                         interp_point(held_frame[1], cur1, pos[15:0]),
                                         ich, och));
            pos += cfg_rate_step;
         end
         if (pos < ONE_FRAME) begin
            pos = ONE_FRAME;
         end
         pos -= ONE_FRAME;
         if (pos > lirs_pkg::PHASE_MAX) begin
            pos = lirs_pkg::PHASE_MAX;
         end
         phase_acc = pos[19:0];
      end
      if (run_q.size() > 0) begin
         run_q[run_q.size()-1].last = 1'b1;
      end
      foreach (run_q[i]) begin
         pending_frames.push_back(run_q[i]);
      end
      held_frame[0] = cur0;
      held_frame[1] = cur1;
   endtask

   task automatic send_frame(input logic [SW-1:0] a, input logic [SW-1:0] b,
      input logic disc);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_sample_a   <= a;
      req_in_sample_b   <= b;
      req_discontinuity <= disc;
      do @(posedge clock); while (!req_ready);
      predict_frames(a, b, disc);
      items_sent++;
   endtask

   // let runs with no result drain too
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic put_csr(input lirs_pkg::csr_index_type idx, input csr_word_type data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         lirs_pkg::CSR_RATE_STEP:     cfg_rate_step = data[lirs_pkg::STEP_W-1:0];
         lirs_pkg::CSR_IN_CHANNELS:   cfg_in_count  = data[1:0];
         lirs_pkg::CSR_OUT_CHANNELS:  cfg_out_count = data[1:0];
         lirs_pkg::CSR_SAMPLE_FORMAT: cfg_wide      = data[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input csr_word_type rate, input csr_word_type in_cnt,
      input csr_word_type out_cnt, input csr_word_type fmt);
      wait_idle();
      put_csr(lirs_pkg::CSR_RATE_STEP, rate);
      put_csr(lirs_pkg::CSR_IN_CHANNELS, in_cnt);
      put_csr(lirs_pkg::CSR_OUT_CHANNELS, out_cnt);
      put_csr(lirs_pkg::CSR_SAMPLE_FORMAT, fmt);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic test_unit_step();
      // reset settings: unit step, stereo, 16-bit samples with junk in the upper half
      send_frame(32'h0000_7FFF, 32'hFFFF_8000, 1'b1);
      send_frame(32'hABCD_8000, 32'h1234_7FFF, 1'b0);
      send_frame(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
   endtask

   task automatic test_full_scale_interp();
      set_config(21'h004000, 21'd2, 21'd2, 21'd1);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
   endtask

   task automatic test_run_cap();
      set_config(21'd4096, 21'd2, 21'd2, 21'd1);
      send_frame(32'h4000_0000, 32'hC000_0001, 1'b0);
      // zero step never reaches the next frame
      set_config(21'd0, 21'd2, 21'd2, 21'd1);
      send_frame(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      set_config(21'd4000, 21'd2, 21'd2, 21'd0);
      send_frame(32'h0000_1234, 32'h0000_EDCB, 1'b0);
      send_frame(32'h0000_8000, 32'h0000_7FFF, 1'b0);
   endtask

   task automatic test_downsampling();
      set_config(21'd1048576, 21'd2, 21'd2, 21'd1);
      send_frame(32'h1111_1111, 32'hEEEE_EEEE, 1'b1);
      send_frame(32'h2222_2222, 32'hDDDD_DDDD, 1'b0);
      send_frame(32'h3333_3333, 32'hCCCC_CCCC, 1'b0);
      // largest step saturates the phase
      set_config(21'h1FFFFF, 21'd2, 21'd2, 21'd1);
      send_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      send_frame(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
   endtask

   task automatic test_channel_map();
      set_config(21'h008000, 21'd1, 21'd2, 21'd1);
      send_frame(32'h5A5A_5A5A, 32'h1234_5678, 1'b1);
      set_config(21'h008000, 21'd2, 21'd1, 21'd0);
      send_frame(32'h0000_7FFF, 32'h0000_8000, 1'b0);
      set_config(21'h008000, 21'd0, 21'd3, 21'd1);
      send_frame(32'hA5A5_A5A5, 32'h7FFF_FFFF, 1'b0);
      set_config(21'h008000, 21'd3, 21'd0, 21'd0);
      send_frame(32'h0000_8001, 32'h0000_7FFE, 1'b0);
      send_frame(32'h0000_4000, 32'h0000_C000, 1'b1);
   endtask

   function automatic logic [SW-1:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic test_random_streams();
      csr_word_type rate;
      for (int ph = 0; ph < 6; ph++) begin
         case ($urandom_range(0, 5))
            0: rate = lirs_pkg::UNIT_STEP;
            1: rate = csr_word_type'($urandom_range(4096, 16384));
            2: rate = csr_word_type'($urandom_range(16385, 65535));
            3: rate = csr_word_type'($urandom_range(65537, 1048576));
            4: rate = csr_word_type'($urandom_range(0, 2097151));
            default: rate = $urandom_range(0, 1) ? 21'd4096 : 21'd1048576;
         endcase
         set_config(rate, csr_word_type'($urandom_range(0, 2097151)),
                    csr_word_type'($urandom_range(0, 2097151)),
                    csr_word_type'($urandom_range(0, 2097151)));
         no_idle = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 24; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               no_idle = !no_idle;
            end
            send_frame(pick_sample(), pick_sample(), $urandom_range(0, 11) == 0);
         end
      end
      no_idle = 1'b0;
   endtask

   // result side: random stall per item, then compare with the oldest prediction
   initial begin
      int            stall;
      out_frame_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         results_checked++;
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected result a=%h b=%h last=%b", $realtime,
                     rsp_out_sample_a, rsp_out_sample_b, rsp_last_of_run);
            mismatch_count++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_out_sample_a !== want.sample_a) begin
               $display("%0t: out_sample_a expected %h got %h", $realtime,
                        want.sample_a, rsp_out_sample_a);
               mismatch_count++;
            end
            if (rsp_out_sample_b !== want.sample_b) begin
               $display("%0t: out_sample_b expected %h got %h", $realtime,
                        want.sample_b, rsp_out_sample_b);
               mismatch_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run expected %b got %b", $realtime,
                        want.last, rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unit_step();
      test_full_scale_interp();
      test_run_cap();
      test_downsampling();
      test_channel_map();
      test_random_streams();
      wait_idle();
      repeat (40) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $display("%0t: %0d predicted results never arrived", $realtime,
                  pending_frames.size());
         mismatch_count++;
      end
      $display("sent %0d frames under %0d register settings, checked %0d results",
               items_sent, settings_applied + 1, results_checked);
      $display("%0d mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/lirs_pkg.sv
design/lirs_csr.sv
design/lirs_ctrl.sv
design/lirs_dp.sv
design/linear_interp_resampler_upmix_unit.sv
tb/tb_linear_interp_resampler_upmix_unit.sv
